// File: design/bptc_pkg.sv
// Package: register indexes, widths and fixed constants for the compensation pipeline
package bptc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int IDX_W   = 3;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 32;

    // calibration register indexes
    localparam logic [IDX_W-1:0] REG_SENS      = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd1;
    localparam logic [IDX_W-1:0] REG_SENS_TC   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_TC = 3'd3;
    localparam logic [IDX_W-1:0] REG_REF_TEMP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_SLOPE = 3'd5;

    // temperature thresholds in 0.01 C
    localparam logic signed [TEMP_W:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TEMP_W:0] TEMP_COLD = 20'sd1500;

    // saturation limits, held at the width of the final difference
    localparam logic signed [42:0] PRES_MAX = 43'sd2147483647;
    localparam logic signed [42:0] PRES_MIN = -43'sd2147483648;

endpackage

// File: design/baro_pressure_temp_compensation.sv
// Top level: seven-stage pipelined second-order barometric compensation
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------------------
//  sample in | in        | start / busy            | i_raw_pressure, i_raw_temperature
//  result    | out       | o_valid (one-cycle)     | o_temperature_centi, o_pressure_pa,
//            |           |                         | o_pressure_clipped
//  config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word enters per cycle and moves through all seven registered stages. The depth
// is set by the two multiplier rows (dT products, squares) and the split 24x38
// pressure product, each followed by a register.
// busy is always low and o_cfg_ready always high; the result side cannot stall, so
// the pipeline never holds. Synchronous active-low reset clears the valid bits and
// the six calibration registers (to zero).
module baro_pressure_temp_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bptc_pkg::RAW_W-1:0]          i_raw_pressure,
    input  logic [bptc_pkg::RAW_W-1:0]          i_raw_temperature,
    output logic                                o_valid,
    output logic signed [bptc_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic signed [bptc_pkg::PRES_W-1:0]  o_pressure_pa,
    output logic                                o_pressure_clipped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bptc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [bptc_pkg::COEFF_W-1:0]        i_cfg_data
);

    localparam int NSTG = 7;

    // calibration words
    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic [NSTG-1:0] r_vld;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bptc_pkg::REG_SENS:       r_c1 <= i_cfg_data;
                bptc_pkg::REG_OFFSET:     r_c2 <= i_cfg_data;
                bptc_pkg::REG_SENS_TC:    r_c3 <= i_cfg_data;
                bptc_pkg::REG_OFFSET_TC:  r_c4 <= i_cfg_data;
                bptc_pkg::REG_REF_TEMP:   r_c5 <= i_cfg_data;
                bptc_pkg::REG_TEMP_SLOPE: r_c6 <= i_cfg_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], start};
        end
    end

    // ---- stage 1: dT = D2 - C5*256 ----
    logic signed [24:0] n_dt, r_dt;
    logic [23:0] r_d1_s1;
    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_c5, 8'd0});

    always_ff @(posedge i_clk) begin
        r_dt    <= n_dt;
        r_d1_s1 <= i_raw_pressure;
    end

    // ---- stage 2: dT products ----
    logic signed [41:0] r_pt, r_poff, r_psens;
    logic signed [49:0] r_psq;
    logic [23:0] r_d1_s2;

    always_ff @(posedge i_clk) begin
        r_pt    <= r_dt * $signed({1'b0, r_c6});
        r_poff  <= r_dt * $signed({1'b0, r_c4});
        r_psens <= r_dt * $signed({1'b0, r_c3});
        r_psq   <= r_dt * r_dt;
        r_d1_s2 <= r_d1_s1;
    end

    // ---- stage 3: first-order TEMP, OFF, SENS and T2 ----
    logic signed [41:0] w_t_sh, w_off_sh, w_sens_sh;
    logic signed [18:0] n_temp, r_temp;
    logic signed [39:0] n_off1, r_off1;
    logic signed [37:0] n_sens1, r_sens1;
    logic [17:0] r_t2;
    logic [23:0] r_d1_s3;

    assign w_t_sh    = r_pt >>> 23;
    assign w_off_sh  = r_poff >>> 7;
    assign w_sens_sh = r_psens >>> 8;
    assign n_temp    = w_t_sh[18:0] + bptc_pkg::TEMP_REF[18:0];
    assign n_off1    = $signed({8'd0, r_c2, 16'd0}) + w_off_sh[39:0];
    assign n_sens1   = $signed({7'd0, r_c1, 15'd0}) + w_sens_sh[37:0];

    always_ff @(posedge i_clk) begin
        r_temp  <= n_temp;
        r_off1  <= n_off1;
        r_sens1 <= n_sens1;
        r_t2    <= r_psq[48:31];   // dT*dT is never negative
        r_d1_s3 <= r_d1_s2;
    end

    // ---- stage 4: squares of distance from the two thresholds ----
    logic signed [19:0] w_d, w_e;
    logic signed [39:0] r_dd, r_ee;
    logic r_lt, r_cold;
    logic signed [18:0] r_temp_s4;
    logic signed [39:0] r_off_s4;
    logic signed [37:0] r_sens_s4;
    logic [17:0] r_t2_s4;
    logic [23:0] r_d1_s4;

    assign w_d = 20'(r_temp) - bptc_pkg::TEMP_REF;
    assign w_e = 20'(r_temp) + bptc_pkg::TEMP_COLD;

    always_ff @(posedge i_clk) begin
        r_dd      <= w_d * w_d;
        r_ee      <= w_e * w_e;
        r_lt      <= w_d[19];      // TEMP < 20.00
        r_cold    <= w_e[19];      // TEMP < -15.00
        r_temp_s4 <= r_temp;
        r_off_s4  <= r_off1;
        r_sens_s4 <= r_sens1;
        r_t2_s4   <= r_t2;
        r_d1_s4   <= r_d1_s3;
    end

    // ---- stage 5: apply OFF2 / SENS2 and T2 ----
    logic signed [41:0] w_dd, w_ee, w_off_c, w_sens_c, w_off2, w_sens2;
    logic signed [18:0] n_temp_out, r_temp_s5;
    logic signed [39:0] r_off_s5;
    logic signed [37:0] r_sens_s5;
    logic [23:0] r_d1_s5;

    assign w_dd = 42'(r_dd);
    assign w_ee = 42'(r_ee);

    always_comb begin
        w_off_c  = '0;
        w_sens_c = '0;
        if (r_lt) begin
            w_off_c  = ((w_dd <<< 2) + w_dd) >>> 1;
            w_sens_c = ((w_dd <<< 2) + w_dd) >>> 2;
            if (r_cold) begin
                w_off_c  = w_off_c + ((w_ee <<< 3) - w_ee);
                w_sens_c = w_sens_c + (((w_ee <<< 3) + (w_ee <<< 1) + w_ee) >>> 1);
            end
        end
    end

    assign w_off2     = 42'(r_off_s4) - w_off_c;
    assign w_sens2    = 42'(r_sens_s4) - w_sens_c;
    assign n_temp_out = r_lt ? (r_temp_s4 - $signed({1'b0, r_t2_s4})) : r_temp_s4;

    always_ff @(posedge i_clk) begin
        r_temp_s5 <= n_temp_out;
        r_off_s5  <= w_off2[39:0];
        r_sens_s5 <= w_sens2[37:0];
        r_d1_s5   <= r_d1_s4;
    end

    // ---- stage 6: D1*SENS as two partial products ----
    logic [42:0] r_plo;
    logic signed [43:0] r_phi;
    logic signed [18:0] r_temp_s6;
    logic signed [39:0] r_off_s6;

    always_ff @(posedge i_clk) begin
        r_plo     <= r_d1_s5 * r_sens_s5[18:0];
        r_phi     <= $signed({1'b0, r_d1_s5}) * $signed(r_sens_s5[37:19]);
        r_temp_s6 <= r_temp_s5;
        r_off_s6  <= r_off_s5;
    end

    // ---- stage 7: combine, shift, subtract OFF, saturate ----
    logic signed [62:0] w_prod;
    logic signed [62:0] w_q;
    logic signed [42:0] w_r, w_p;
    logic signed [31:0] n_pres;
    logic n_clip;

    assign w_prod = (63'(r_phi) <<< 19) + $signed({20'd0, r_plo});
    assign w_q    = w_prod >>> 21;
    assign w_r    = w_q[42:0] - 43'(r_off_s6);
    assign w_p    = w_r >>> 15;

    always_comb begin
        n_pres = w_p[31:0];
        n_clip = 1'b0;
        if (w_p > bptc_pkg::PRES_MAX) begin
            n_pres = bptc_pkg::PRES_MAX[31:0];
            n_clip = 1'b1;
        end else if (w_p < bptc_pkg::PRES_MIN) begin
            n_pres = bptc_pkg::PRES_MIN[31:0];
            n_clip = 1'b1;
        end
    end

    logic signed [18:0] r_temp_o;
    logic signed [31:0] r_pres_o;
    logic r_clip_o;

    always_ff @(posedge i_clk) begin
        r_temp_o <= r_temp_s6;
        r_pres_o <= n_pres;
        r_clip_o <= n_clip;
    end

    assign o_temperature_centi = r_temp_o;
    assign o_pressure_pa       = r_pres_o;
    assign o_pressure_clipped  = r_clip_o;

endmodule
